/* design/ptta_pkg.sv */
// Shared types, widths, register indexes and character codes for the
// periodic temperature-to-ASCII unit. No dependencies.
`default_nettype none
package ptta_pkg;

  localparam int ADC_BITS     = 10;
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int DIV_BITS     = 8;
  localparam int SLOPE_BITS   = 16;
  localparam int REF_BITS     = 10;
  localparam int TEMP_BITS    = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int NUM_DIGITS   = 5;
  localparam int PROD_BITS    = SLOPE_BITS + ADC_BITS;
  localparam int QUOT_BITS    = 17;
  localparam int SCALE        = 1000;
  localparam int SCALE_BITS   = 10;

  localparam logic [DIV_BITS-1:0]   TICK_DIVISOR_RST = 8'd20;
  localparam logic [SLOPE_BITS-1:0] SLOPE_MILLI_RST  = 16'd1064;
  localparam logic [REF_BITS-1:0]   REF_CODE_RST     = 10'd347;
  localparam logic [REF_BITS-1:0]   REF_TEMP_RST     = 10'd55;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TICK_DIVISOR = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SLOPE_MILLI  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REF_CODE     = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REF_TEMP     = 2'd3;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_LF   = 8'h0A;
  localparam logic [7:0] ASCII_CR   = 8'h0D;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_digits_t;

endpackage
`default_nettype wire

/* design/ptta_conv.sv */
// Linear calibration: serial shift-add multiply, then restoring divide by 1000,
// then offset and saturation. Depends on ptta_pkg.
`default_nettype none
module ptta_conv #(
  parameter int SAMPLE_BITS = ptta_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [ptta_pkg::ADC_BITS-1:0]   sample,
  input  wire logic [ptta_pkg::SLOPE_BITS-1:0] slope_milli,
  input  wire logic [ptta_pkg::REF_BITS-1:0]   ref_code,
  input  wire logic [ptta_pkg::REF_BITS-1:0]   ref_temp,
  output logic                                 done,
  output logic [ptta_pkg::TEMP_BITS-1:0]       temp
);
  import ptta_pkg::*;

  localparam int UsedBits = (SAMPLE_BITS < ADC_BITS) ? SAMPLE_BITS : ADC_BITS;
  localparam logic [ADC_BITS-1:0] SampleMask = ADC_BITS'((1 << UsedBits) - 1);
  localparam int CntW = $clog2(PROD_BITS);
  localparam logic [CntW-1:0] MulLast = CntW'(ADC_BITS - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(PROD_BITS - 1);
  localparam logic [SCALE_BITS:0] ScaleK = (SCALE_BITS + 1)'(SCALE);

  typedef enum logic [1:0] {C_IDLE, C_MUL, C_DIV, C_FIN} conv_state_t;

  conv_state_t           state_r;
  logic [CntW-1:0]       cnt_r;
  logic                  neg_r;
  logic [PROD_BITS-1:0]  acc_r;
  logic [PROD_BITS-1:0]  mcand_r;
  logic [ADC_BITS-1:0]   mplier_r;
  logic [SCALE_BITS-1:0] rem_r;
  logic                  done_r;
  logic [TEMP_BITS-1:0]  temp_r;

  logic [ADC_BITS:0]     diff;
  logic [ADC_BITS-1:0]   mag;
  logic [SCALE_BITS:0]   trial;
  logic                  qbit;
  logic [QUOT_BITS-1:0]  quot;
  logic [QUOT_BITS:0]    sum;
  logic [TEMP_BITS-1:0]  temp_nxt;

  always_comb begin
    diff  = {1'b0, sample & SampleMask} - {1'b0, ref_code};
    mag   = diff[ADC_BITS] ? ADC_BITS'(-diff) : diff[ADC_BITS-1:0];
    trial = {rem_r, acc_r[PROD_BITS-1]};
    qbit  = (trial >= ScaleK);
    quot  = acc_r[QUOT_BITS-1:0];
    sum   = {1'b0, quot} + (QUOT_BITS + 1)'(ref_temp);
    if (!neg_r) begin
      temp_nxt = (sum[QUOT_BITS:TEMP_BITS] != '0) ? '1 : sum[TEMP_BITS-1:0];
    end else if (quot > QUOT_BITS'(ref_temp)) begin
      temp_nxt = '0;
    end else begin
      temp_nxt = TEMP_BITS'(ref_temp - quot[REF_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            neg_r    <= diff[ADC_BITS];
            mplier_r <= mag;
            mcand_r  <= PROD_BITS'(slope_milli);
            acc_r    <= '0;
            cnt_r    <= '0;
            state_r  <= C_MUL;
          end
        end
        C_MUL: begin
          // add shifted multiplicand for each set bit of the magnitude
          if (mplier_r[0]) acc_r <= acc_r + mcand_r;
          mcand_r  <= {mcand_r[PROD_BITS-2:0], 1'b0};
          mplier_r <= mplier_r >> 1;
          if (cnt_r == MulLast) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            state_r <= C_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        C_DIV: begin
          // one quotient bit per cycle, shifted into the product register
          rem_r <= qbit ? SCALE_BITS'(trial - ScaleK) : trial[SCALE_BITS-1:0];
          acc_r <= {acc_r[PROD_BITS-2:0], qbit};
          if (cnt_r == DivLast) begin
            state_r <= C_FIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        C_FIN: begin
          temp_r  <= temp_nxt;
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign temp = temp_r;

endmodule
`default_nettype wire

/* design/ptta_bcd.sv */
// Binary to BCD by shift-and-add-3, one input bit per cycle.
// Depends on ptta_pkg.
`default_nettype none
module ptta_bcd (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [ptta_pkg::TEMP_BITS-1:0] bin,
  output logic                                done,
  output ptta_pkg::bcd_digits_t               digits
);
  import ptta_pkg::*;

  localparam int CntW = $clog2(TEMP_BITS);
  localparam logic [CntW-1:0] CntLast = CntW'(TEMP_BITS - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CntW-1:0]      cnt_r;
  logic [TEMP_BITS-1:0] bin_r;
  bcd_digits_t          bcd_r;
  bcd_digits_t          adj;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        bin_r  <= bin;
        bcd_r  <= '0;
      end else if (busy_r) begin
        // shift the adjusted digits left by one, drop the top bit
        bcd_r <= {adj[NUM_DIGITS-1][2:0], adj[NUM_DIGITS-2:0], bin_r[TEMP_BITS-1]};
        bin_r <= {bin_r[TEMP_BITS-2:0], 1'b0};
        if (cnt_r == CntLast) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign digits = bcd_r;

endmodule
`default_nettype wire

/* design/ptta_emit.sv */
// Character sequencer: digits without leading zeros, then LF and CR, into
// a registered valid/ready output. Depends on ptta_pkg.
`default_nettype none
module ptta_emit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire ptta_pkg::bcd_digits_t digits,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_char,
  output logic                       out_last
);
  import ptta_pkg::*;

  localparam int IdxW = $clog2(NUM_DIGITS);

  typedef enum logic [1:0] {E_IDLE, E_DIG, E_LF, E_CR} emit_state_t;

  emit_state_t  state_r;
  logic [IdxW-1:0] idx_r;
  bcd_digits_t  dig_r;
  logic         valid_r;
  logic [7:0]   char_r;
  logic         last_r;
  logic         slot_free;
  logic [IdxW-1:0] top_idx;

  // index of the most significant nonzero digit, zero if all are zero
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits[i] != 4'd0) top_idx = IdxW'(i);
    end
  end

  assign slot_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (out_ready) valid_r <= 1'b0;
      unique case (state_r)
        E_IDLE: begin
          if (start) begin
            dig_r   <= digits;
            idx_r   <= top_idx;
            state_r <= E_DIG;
          end
        end
        E_DIG: begin
          if (slot_free) begin
            valid_r <= 1'b1;
            char_r  <= ASCII_ZERO + {4'd0, dig_r[idx_r]};
            last_r  <= 1'b0;
            if (idx_r == '0) state_r <= E_LF;
            else idx_r <= idx_r - 1'b1;
          end
        end
        E_LF: begin
          if (slot_free) begin
            valid_r <= 1'b1;
            char_r  <= ASCII_LF;
            last_r  <= 1'b0;
            state_r <= E_CR;
          end
        end
        E_CR: begin
          if (slot_free) begin
            valid_r <= 1'b1;
            char_r  <= ASCII_CR;
            last_r  <= 1'b1;
            state_r <= E_IDLE;
          end
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

/* design/periodic_temp_to_ascii_unit.sv */
// Top level: tick counter, configuration registers, conversion chain.
// Depends on ptta_pkg, ptta_conv, ptta_bcd, ptta_emit.
//
//   channel  direction  signals
//   in       input      in_valid / in_ready, in_adc_sample
//   out      output     out_valid / out_ready, out_char, out_last_char
//   cfg      input      cfg_we, cfg_index, cfg_wdata
//
// A tick that does not reach the divisor only advances the tick counter. A tick that fires
// holds in_ready low until its CR is taken: shift-add multiply, restoring divide,
// offset and clamp, BCD load, BCD conversion, sequencer load, then the characters
// (3 to 7) through the output register. Once the CR transaction completes, the
// next tick can be taken in the following cycle. A low out_ready stalls the
// character sequencer only. Synchronous active-low reset restores the register
// defaults.
`default_nettype none
module periodic_temp_to_ascii_unit #(
  parameter int SAMPLE_BITS = ptta_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [ptta_pkg::ADC_BITS-1:0]      in_adc_sample,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [7:0]                              out_char,
  output logic                                    out_last_char,
  input  wire logic                               cfg_we,
  input  wire logic [ptta_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [ptta_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import ptta_pkg::*;

  logic [DIV_BITS-1:0]   tick_divisor_r;
  logic [SLOPE_BITS-1:0] slope_milli_r;
  logic [REF_BITS-1:0]   ref_code_r;
  logic [REF_BITS-1:0]   ref_temp_r;
  logic [DIV_BITS-1:0]   tick_count_r;
  logic                  busy_r;

  logic [DIV_BITS-1:0]   tick_count_nxt;
  logic                  fire;
  logic                  accept;
  logic                  conv_done;
  logic [TEMP_BITS-1:0]  temp;
  logic                  bcd_done;
  bcd_digits_t           digits;
  logic                  emit_valid;
  logic                  emit_last;

  assign in_ready       = !busy_r;
  assign accept         = in_valid && in_ready;
  assign tick_count_nxt = tick_count_r + 1'b1;
  assign fire           = (tick_count_nxt >= tick_divisor_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_divisor_r <= TICK_DIVISOR_RST;
      slope_milli_r  <= SLOPE_MILLI_RST;
      ref_code_r     <= REF_CODE_RST;
      ref_temp_r     <= REF_TEMP_RST;
      tick_count_r   <= '0;
      busy_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TICK_DIVISOR: tick_divisor_r <= cfg_wdata[DIV_BITS-1:0];
          CFG_SLOPE_MILLI:  slope_milli_r  <= cfg_wdata[SLOPE_BITS-1:0];
          CFG_REF_CODE:     ref_code_r     <= cfg_wdata[REF_BITS-1:0];
          CFG_REF_TEMP:     ref_temp_r     <= cfg_wdata[REF_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        tick_count_r <= fire ? '0 : tick_count_nxt;
        if (fire) busy_r <= 1'b1;
      end
      // release the input once the closing CR transaction completes
      if (emit_valid && out_ready && emit_last) busy_r <= 1'b0;
    end
  end

  ptta_conv #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept && fire),
    .sample     (in_adc_sample),
    .slope_milli(slope_milli_r),
    .ref_code   (ref_code_r),
    .ref_temp   (ref_temp_r),
    .done       (conv_done),
    .temp       (temp)
  );

  ptta_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_done),
    .bin   (temp),
    .done  (bcd_done),
    .digits(digits)
  );

  ptta_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (bcd_done),
    .digits   (digits),
    .out_valid(emit_valid),
    .out_ready(out_ready),
    .out_char (out_char),
    .out_last (emit_last)
  );

  assign out_valid     = emit_valid;
  assign out_last_char = emit_last;

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for periodic_temp_to_ascii_unit: directed table, then random
// calibrations and ADC ticks checked character by character against a local predictor.
// Depends on ptta_pkg and the unit's RTL.
module tb;
  import ptta_pkg::*;

  localparam int RANDOM_TICKS = 350;
  localparam int DRAIN_CYCLES = 80;
  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_AT = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;
  localparam logic [ADC_BITS-1:0] SAMPLE_MASK = ADC_BITS'((1 << SAMPLE_BITS_DEF) - 1);

  typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [CFG_IDX_BITS-1:0]   idx;
    logic [CFG_DATA_BITS-1:0]  data;
    logic [ADC_BITS-1:0]       sample;
    string                     digits;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_exp_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [ADC_BITS-1:0]      in_adc_sample = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [7:0]               out_char;
  logic                     out_last_char;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_TICK_DIVISOR;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // predictor copy of the unit's registers and tick counter
  logic [DIV_BITS-1:0]   exp_divisor = TICK_DIVISOR_RST;
  logic [SLOPE_BITS-1:0] exp_slope = SLOPE_MILLI_RST;
  logic [REF_BITS-1:0]   exp_ref_code = REF_CODE_RST;
  logic [REF_BITS-1:0]   exp_ref_temp = REF_TEMP_RST;
  logic [DIV_BITS-1:0]   exp_ticks = '0;

  char_exp_t pending_chars[$];
  int        bad_chars = 0;
  int        tick_total = 0;
  int        stuck_cycles = 0;
  bit        dut_busy = 1'b0;
  bit        tx_quiet = 1'b0;
  bit        rx_quiet = 1'b0;

  dir_row_t dir_rows [29] = '{
    '{ROW_CFG,  CFG_TICK_DIVISOR, 16'd1,     10'd0,    ""},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd347,  "55"},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd1023, "774"},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd0,    "0"},
    // one code below reference: quotient truncates toward zero
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd346,  "54"},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd400,  ""},
    '{ROW_CFG,  CFG_SLOPE_MILLI,  16'd65535, 10'd0,    ""},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd1023, "44356"},
    '{ROW_CFG,  CFG_REF_CODE,     16'd0,     10'd0,    ""},
    '{ROW_CFG,  CFG_REF_TEMP,     16'd1023,  10'd0,    ""},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd1023, "65535"},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd0,    "1023"},
    '{ROW_CFG,  CFG_REF_CODE,     16'd1023,  10'd0,    ""},
    '{ROW_CFG,  CFG_REF_TEMP,     16'd0,     10'd0,    ""},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd0,    "0"},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd1023, "0"},
    '{ROW_CFG,  CFG_SLOPE_MILLI,  16'd0,     10'd0,    ""},
    '{ROW_CFG,  CFG_REF_TEMP,     16'd7,     10'd0,    ""},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd512,  "7"},
    // zero divisor fires on every tick
    '{ROW_CFG,  CFG_TICK_DIVISOR, 16'd0,     10'd0,    ""},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd5,    "7"},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd1000, "7"},
    // count up under a large divisor, then lower it below the count
    '{ROW_CFG,  CFG_TICK_DIVISOR, 16'd255,   10'd0,    ""},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd17,   ""},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd600,  ""},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd1023, ""},
    '{ROW_CFG,  CFG_REF_TEMP,     16'd9,     10'd0,    ""},
    '{ROW_CFG,  CFG_TICK_DIVISOR, 16'd2,     10'd0,    ""},
    '{ROW_TICK, CFG_TICK_DIVISOR, 16'd0,     10'd77,   "9"}
  };

  periodic_temp_to_ascii_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_adc_sample (in_adc_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_last_char (out_last_char),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the tick counter; on a firing tick return the decimal reading.
  function automatic string reading_for_tick(input logic [ADC_BITS-1:0] sample);
    longint code;
    longint temp;
    exp_ticks = exp_ticks + 8'd1;
    if (exp_ticks < exp_divisor) return "";
    exp_ticks = '0;
    code = longint'(sample & SAMPLE_MASK);
    temp = longint'(exp_slope) * (code - longint'(exp_ref_code)) / SCALE
           + longint'(exp_ref_temp);
    if (temp < 0) temp = 0;
    if (temp > 65535) temp = 65535;
    return $sformatf("%0d", temp);
  endfunction

  // Random 16-bit word whose low ten bits often sit at an extreme.
  function automatic logic [CFG_DATA_BITS-1:0] edgy_code();
    logic [CFG_DATA_BITS-1:0] v;
    v = CFG_DATA_BITS'($urandom);
    case ($urandom_range(0, 7))
      0: v[REF_BITS-1:0] = '0;
      1: v[REF_BITS-1:0] = '1;
      default: ;
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    // drain all readings and let a non-firing tick settle before touching registers
    if (dut_busy) begin
      in_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      dut_busy = 1'b0;
    end
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TICK_DIVISOR: exp_divisor  = data[DIV_BITS-1:0];
      CFG_SLOPE_MILLI:  exp_slope    = data[SLOPE_BITS-1:0];
      CFG_REF_CODE:     exp_ref_code = data[REF_BITS-1:0];
      CFG_REF_TEMP:     exp_ref_temp = data[REF_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic send_tick(input logic [ADC_BITS-1:0] sample, input string typed);
    int    gap;
    string reading;
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_adc_sample <= sample;
    do @(posedge clk); while (!in_ready);
    dut_busy = 1'b1;
    tick_total++;
    reading = reading_for_tick(sample);
    if (typed != "") reading = typed;
    if (reading != "") begin
      for (int k = 0; k < reading.len(); k++)
        pending_chars.push_back(char_exp_t'{reading[k], 1'b0});
      pending_chars.push_back(char_exp_t'{ASCII_LF, 1'b0});
      pending_chars.push_back(char_exp_t'{ASCII_CR, 1'b1});
    end
  endtask

  initial begin
    int                       dir_ticks;
    int                       phase_len;
    int                       r;
    logic [CFG_DATA_BITS-1:0] word;
    logic [DIV_BITS-1:0]      div_pick;
    logic [ADC_BITS-1:0]      sample;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else send_tick(dir_rows[i].sample, dir_rows[i].digits);
    end
    dir_ticks = tick_total;

    while (tick_total < dir_ticks + RANDOM_TICKS) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(0, 9);
        div_pick = (r < 6) ? DIV_BITS'($urandom_range(0, 4)) :
                   (r < 8) ? DIV_BITS'($urandom_range(5, 24)) :
                   (r == 8) ? 8'd255 : 8'd1;
        write_reg(CFG_TICK_DIVISOR, {8'($urandom), div_pick});
      end
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(0, 9);
        word = (r == 0) ? 16'd0 : (r == 1) ? 16'd65535 :
               (r < 6) ? 16'($urandom_range(500, 2000)) : 16'($urandom);
        write_reg(CFG_SLOPE_MILLI, word);
      end
      if ($urandom_range(0, 1)) write_reg(CFG_REF_CODE, edgy_code());
      if ($urandom_range(0, 1)) write_reg(CFG_REF_TEMP, edgy_code());
      phase_len = $urandom_range(8, 30);
      repeat (phase_len) begin
        word = edgy_code();
        sample = word[ADC_BITS-1:0];
        // land near the reference point now and then
        if ($urandom_range(0, 7) == 0)
          sample = exp_ref_code + ADC_BITS'($urandom_range(0, 4)) - 10'd2;
        send_tick(sample, "");
      end
    end

    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_chars == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stall before each character, one long hold-off
  // partway through so the unit backs up and blocks its input.
  initial begin
    int stall;
    int taken;
    taken = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 13);
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  always @(posedge clk) begin
    char_exp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        bad_chars++;
        if (bad_chars <= MAX_REPORTS)
          $display("unexpected transaction: char 0x%02h last %0b", out_char, out_last_char);
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch || out_last_char !== want.last) begin
          bad_chars++;
          if (bad_chars <= MAX_REPORTS)
            $display("char mismatch: expected 0x%02h last %0b, got 0x%02h last %0b",
                     want.ch, want.last, out_char, out_last_char);
        end
      end
    end
  end

  // Drop the run when neither channel nor the register port moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
